// ===== rtl/core/udiv64_pkg.sv =====
// Package for the 64-bit unsigned divider: operand, result and pipeline stage types.
// No dependencies; used by every module in rtl/core and by the checker.
package udiv64_pkg;

    localparam int DIV_WIDTH  = 64;
    localparam int DIV_STAGES = DIV_WIDTH;   // one quotient bit per stage

    typedef struct packed {
        logic [DIV_WIDTH-1:0] numerator;
        logic [DIV_WIDTH-1:0] denominator;
    } div_in_t;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] quotient;
        logic [DIV_WIDTH-1:0] remainder;
        logic                 divide_by_zero;
    } div_out_t;

    // nq holds the numerator bits still to be consumed (top) and the
    // quotient bits already produced (bottom), shifted left each stage.
    typedef struct packed {
        logic                 valid;
        logic [DIV_WIDTH-1:0] rem;
        logic [DIV_WIDTH-1:0] nq;
        logic [DIV_WIDTH-1:0] den;
        logic                 dbz;
    } stage_t;

endpackage

// ===== rtl/core/unsigned_divide_64_top.sv =====
// Top level of the 64-by-64-bit unsigned divider: a 64-stage restoring pipeline.
// Depends on udiv64_pkg and udiv64_stage.
//
// Usage
//   Request channel: drive request (numerator, denominator) and raise start;
//   a transfer takes place at each rising edge with start high and busy low.
//   busy is held low, so a new request may be presented in every cycle.
//   Result channel: done is high for exactly one cycle while result carries
//   quotient, remainder and divide_by_zero; the receiver cannot hold it off.
// Stages and throughput
//   One quotient bit is resolved per pipeline stage, 64 stages in all, each a
//   65-bit subtract and a select. A transferred request is registered by each stage in
//   turn, and done rises once the last stage register holds it.
//   Throughput is one division per cycle. Results leave in request order.
// Divide by zero
//   The flag is taken at entry and travels with the item; it forces every
//   trial subtraction to succeed, so the pipeline gives an all-ones quotient
//   and, with a zero divisor subtracted, the numerator as remainder.
// Reset
//   rst_n clears every stage valid bit at once; items in flight are dropped
//   and no done is raised until new requests arrive. Data registers are not
//   reset.
module unsigned_divide_64_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  udiv64_pkg::div_in_t request,
    output logic                done,
    output udiv64_pkg::div_out_t result
);

    localparam int W = udiv64_pkg::DIV_WIDTH;
    localparam int N = udiv64_pkg::DIV_STAGES;

    udiv64_pkg::stage_t stage_bus [0:N];

    // never stalls: one stage per quotient bit, one item enters each cycle
    assign busy = 1'b0;

    // entry: partial remainder starts at zero, numerator loaded into nq
    always_comb
    begin
        stage_bus[0].valid = start & ~busy;
        stage_bus[0].rem   = '0;
        stage_bus[0].nq    = request.numerator;
        stage_bus[0].den   = request.denominator;
        stage_bus[0].dbz   = (request.denominator == {W{1'b0}});
    end

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        udiv64_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage_bus[g]),
            .stage_out (stage_bus[g+1])
        );
    end

    // after the last step nq holds the whole quotient
    assign done                  = stage_bus[N].valid;
    assign result.quotient       = stage_bus[N].nq;
    assign result.remainder      = stage_bus[N].rem;
    assign result.divide_by_zero = stage_bus[N].dbz;

endmodule

// ===== rtl/core/udiv64_stage.sv =====
// One restoring shift-subtract step of the divider, registered at its output.
// Depends on udiv64_pkg.
module udiv64_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  udiv64_pkg::stage_t stage_in,
    output udiv64_pkg::stage_t stage_out
);

    localparam int W = udiv64_pkg::DIV_WIDTH;

    logic               valid_reg;
    logic               valid_next;
    udiv64_pkg::stage_t data_reg;
    udiv64_pkg::stage_t data_next;

    logic [W:0] partial;
    logic [W:0] diff;
    logic       take;

    // shift in the next numerator bit, trial-subtract the divisor;
    // a zero divisor always takes, so the quotient comes out all ones
    always_comb
    begin
        partial = {stage_in.rem, stage_in.nq[W-1]};
        diff    = partial - {1'b0, stage_in.den};
        take    = ~diff[W] | stage_in.dbz;

        valid_next     = stage_in.valid;
        data_next      = stage_in;
        data_next.rem  = take ? diff[W-1:0] : partial[W-1:0];
        data_next.nq   = {stage_in.nq[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload only moves with a live transfer
    always_ff @(posedge clk)
    begin
        if (stage_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// ===== rtl/core/udiv64_checker.sv =====
// Port-level checker for unsigned_divide_64_top, attached by the bind below.
// Depends on udiv64_pkg.
module udiv64_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input udiv64_pkg::div_in_t  request,
    input logic                 done,
    input udiv64_pkg::div_out_t result
);

    localparam int LAT = udiv64_pkg::DIV_STAGES;

    // each transfer comes back as a done once it has passed every stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##64 done)
        else $error("result missing after pipeline latency");

    // no result without a matching transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a request");

    // zero divisor: all-ones quotient, numerator back as remainder
    a_dbz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |->
            (&result.quotient) && (result.remainder == $past(request.numerator, LAT)))
        else $error("divide-by-zero result wrong");

    // otherwise the remainder stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.divide_by_zero) |->
            (result.remainder < $past(request.denominator, LAT)))
        else $error("remainder not below divisor");

endmodule

bind unsigned_divide_64_top udiv64_checker u_udiv64_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

// ===== tb/unsigned_divide_64_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 64-bit unsigned divider top level.
// Depends on udiv64_pkg and unsigned_divide_64_top, which needs udiv64_stage.
module unsigned_divide_64_top_tb;

    // Wait bound for stray results, derived from the pipeline depth.
    localparam int PIPE_LATENCY = udiv64_pkg::DIV_STAGES + 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [udiv64_pkg::DIV_WIDTH-1:0] ALL_ONES = '1;
    localparam logic [udiv64_pkg::DIV_WIDTH-1:0] TOP_BIT  =
        {1'b1, {(udiv64_pkg::DIV_WIDTH-1){1'b0}}};

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    udiv64_pkg::div_in_t  request;
    logic                 done;
    udiv64_pkg::div_out_t result;

    udiv64_pkg::div_out_t expected_results[$];
    int                   failures;
    int                   cycle_count;
    int                   sender_idle_pct;

    unsigned_divide_64_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Restoring shift-subtract division, one quotient bit per step, MSB first.
    // The partial remainder is kept one bit wider so the bit shifted out of the
    // top is never lost; a zero divisor is handled up front.
    function automatic udiv64_pkg::div_out_t compute_division(input udiv64_pkg::div_in_t op);
        udiv64_pkg::div_out_t                res;
        logic [udiv64_pkg::DIV_WIDTH:0]      partial;
        logic [udiv64_pkg::DIV_WIDTH-1:0]    quo;
        res     = '0;
        partial = '0;
        quo     = '0;
        if (op.denominator == '0)
        begin
            res.quotient       = ALL_ONES;
            res.remainder      = op.numerator;
            res.divide_by_zero = 1'b1;
        end
        else
        begin
            for (int i = udiv64_pkg::DIV_WIDTH - 1; i >= 0; i--)
            begin
                partial = {partial[udiv64_pkg::DIV_WIDTH-1:0], op.numerator[i]};
                if (partial >= {1'b0, op.denominator})
                begin
                    partial = partial - {1'b0, op.denominator};
                    quo[i]  = 1'b1;
                end
            end
            res.quotient       = quo;
            res.remainder      = partial[udiv64_pkg::DIV_WIDTH-1:0];
            res.divide_by_zero = 1'b0;
        end
        return res;
    endfunction

    // Monitor: sample both channels at the rising edge, before the block's own
    // updates land. Results are checked against the oldest outstanding
    // prediction; an accepted request queues its prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing outstanding: quotient %h remainder %h flag %b",
                           result.quotient, result.remainder, result.divide_by_zero);
                    failures++;
                end
                else
                begin
                    udiv64_pkg::div_out_t want;
                    want = expected_results.pop_front();
                    if (result.quotient !== want.quotient)
                    begin
                        $error("quotient: expected %h, got %h", want.quotient, result.quotient);
                        failures++;
                    end
                    if (result.remainder !== want.remainder)
                    begin
                        $error("remainder: expected %h, got %h", want.remainder,
                               result.remainder);
                        failures++;
                    end
                    if (result.divide_by_zero !== want.divide_by_zero)
                    begin
                        $error("divide_by_zero: expected %b, got %b", want.divide_by_zero,
                               result.divide_by_zero);
                        failures++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(compute_division(request));
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("unsigned_divide_64_top_tb NOT OK");
            $finish;
        end
    end

    // Drive one division request and hold it until the transfer happens. start
    // is left high afterwards unless idle cycles are drawn, so back-to-back
    // requests never lower and raise it within one time step. Each cycle after
    // a transfer idles with the given chance.
    task automatic send_division(input logic [udiv64_pkg::DIV_WIDTH-1:0] num,
                                 input logic [udiv64_pkg::DIV_WIDTH-1:0] den);
        request.numerator   <= num;
        request.denominator <= den;
        start               <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
    endtask

    // Hold off the sender until the pipeline has delivered everything.
    task automatic wait_until_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // 64-bit value of random bit length, so small and large magnitudes both turn up.
    function automatic logic [udiv64_pkg::DIV_WIDTH-1:0] random_operand();
        logic [udiv64_pkg::DIV_WIDTH-1:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, udiv64_pkg::DIV_WIDTH - 1);
    endfunction

    // Extremes of both fields, divisor above / equal to dividend, top-bit divisors
    // (where the shifted-out bit matters) and a few ordinary cases.
    task automatic test_corner_cases();
        send_division('0, 64'd1);
        send_division(ALL_ONES, 64'd1);
        send_division(ALL_ONES, ALL_ONES);
        send_division(64'd1, ALL_ONES);
        send_division(ALL_ONES, ALL_ONES - 64'd1);
        send_division(ALL_ONES - 64'd1, ALL_ONES);
        send_division(TOP_BIT, 64'd1);
        send_division(TOP_BIT, TOP_BIT);
        send_division(ALL_ONES, TOP_BIT);
        send_division(ALL_ONES, TOP_BIT | 64'd1);
        send_division(64'd100, 64'd7);
        send_division(64'd7, 64'd100);
        send_division(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);
        send_division(TOP_BIT | 64'd1, 64'd3);
        send_division(ALL_ONES, 64'h1_0000_0000);
        send_division(ALL_ONES, 64'hffff_ffff);
        send_division(64'hfedc_ba98_7654_3210, 64'h0000_0001_0000_0001);
        send_division(ALL_ONES, 64'd2);
    endtask

    // Zero divisor: flag set, all-ones quotient, numerator passed back.
    task automatic test_divide_by_zero();
        send_division('0, '0);
        send_division(ALL_ONES, '0);
        send_division(64'd12345, '0);
        send_division(TOP_BIT, '0);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        logic [udiv64_pkg::DIV_WIDTH-1:0] num;
        logic [udiv64_pkg::DIV_WIDTH-1:0] den;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            num = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : random_operand();
            case ($urandom_range(0, 9))
                0:       den = '0;
                1:       den = num;
                2:       den = {$urandom, $urandom};
                3:       den = num + random_operand();
                default: den = random_operand();
            endcase
            send_division(num, den);
        end
    endtask

    // Burst, full stop until every result is back, then another burst.
    task automatic test_pause_until_drained();
        sender_idle_pct = 0;
        repeat (10)
            send_division({$urandom, $urandom}, random_operand());
        wait_until_drained();
        repeat (10)
            send_division(random_operand(), {$urandom, $urandom});
        wait_until_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        failures        = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_divide_by_zero();
        test_pause_until_drained();

        // Sender idles often, then heavily, then never.
        test_random_traffic(330, 22);
        wait_until_drained();
        test_random_traffic(330, 51);
        wait_until_drained();
        test_random_traffic(330, 0);

        wait_until_drained();
        // Catch any stray result arriving after the last expected one.
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (failures == 0)
            $display("unsigned_divide_64_top_tb OK");
        else
            $display("unsigned_divide_64_top_tb NOT OK");
        $finish;
    end

endmodule
